FILE: hdl/kf4_pkg.sv
package kf4_pkg;

    typedef logic signed [31:0] t_q16;
    typedef logic signed [15:0] t_q412;
    typedef logic [63:0]        t_cword;

    localparam int CFG_IDX_W = 4;
    localparam int NCOEF     = 4;
    localparam int DIV_STEPS = 48;
    localparam logic [5:0] DIV_LAST = 6'(DIV_STEPS + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TRANS_ROW0      = 4'd0,
        CFG_TRANS_ROW1      = 4'd1,
        CFG_TRANS_ROW2      = 4'd2,
        CFG_TRANS_ROW3      = 4'd3,
        CFG_OBS_ROW         = 4'd4,
        CFG_NOISE_GAIN_COL  = 4'd5,
        CFG_PROCESS_NOISE   = 4'd6,
        CFG_MEASURE_NOISE   = 4'd7
    } t_cfg_idx;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef enum logic [3:0] {
        PH_PC,
        PH_CP,
        PH_S,
        PH_E,
        PH_XC,
        PH_PCOR,
        PH_XN,
        PH_T,
        PH_PN
    } t_phase;

    typedef struct packed {
        t_phase ph;
        logic   first;
        logic   last;
        logic   aux;
    } t_tag;

    function automatic t_q412 coef(t_cword w, logic [3:0] j);
        t_q412 v;
        v = '0;
        if (j < 4'(NCOEF)) begin
            v = t_q412'(w[{j[1:0], 4'b0000} +: 16]);
        end
        return v;
    endfunction

    function automatic t_q16 sat32(logic signed [63:0] v);
        t_q16 r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

FILE: hdl/kf4_if.sv
interface kf4_meas_if;
    import kf4_pkg::*;
    logic valid;
    logic ready;
    t_q16 measured_position;
    modport source  (output valid, output measured_position, input ready);
    modport sink    (input valid, input measured_position, output ready);
    modport monitor (input valid, input measured_position, input ready);
endinterface

interface kf4_est_if;
    import kf4_pkg::*;
    logic valid;
    logic ready;
    t_q16 est_0;
    t_q16 est_1;
    t_q16 est_2;
    t_q16 est_3;
    logic singular_fault;
    modport source  (output valid, output est_0, output est_1, output est_2, output est_3,
                     output singular_fault, input ready);
    modport sink    (input valid, input est_0, input est_1, input est_2, input est_3,
                     input singular_fault, output ready);
    modport monitor (input valid, input est_0, input est_1, input est_2, input est_3,
                     input singular_fault, input ready);
endinterface

interface kf4_cfg_if;
    import kf4_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    t_cword               data;
    modport source  (output valid, output index, output data, input ready);
    modport sink    (input valid, input index, input data, output ready);
    modport monitor (input valid, input index, input data, input ready);
endinterface

FILE: hdl/kalman_filter_4state_step.sv
// One request in flight: the issue runs use the shared 32x32 MAC pipe, the gain comes
// from the bit-serial gain divider, the pipe drains after each of the 9 phases, and the
// result is then loaded into the result register.
// The next request is taken while a result waits.
// Synchronous active-low reset clears state and covariance (per-entry valid bits) and
// all configuration registers.
module kalman_filter_4state_step #(
    parameter int STATE_SIZE = 4
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    kf4_meas_if.sink i_meas,
    kf4_cfg_if.sink  i_cfg,
    kf4_est_if.source o_est
);
    import kf4_pkg::*;

    localparam int N   = STATE_SIZE;
    localparam int IW  = $clog2(N);
    localparam int CW  = $clog2(N + 1);
    localparam int NN  = N * N;
    localparam int AW  = $clog2(NN);
    localparam int WAW = $clog2(2 * NN);

    // configuration
    t_cword      r_a [4];
    t_cword      r_c;
    t_cword      r_g;
    logic [30:0] r_q;
    logic [30:0] r_r;

    // control
    t_state          r_state, n_state;
    t_phase          r_phase;
    logic [IW-1:0]   r_i, r_j, r_di;
    logic [CW-1:0]   r_m;
    logic [5:0]      r_dcnt;
    t_q16            r_y;

    // vectors
    t_q16 r_pc [N];
    t_q16 r_cp [N];
    t_q16 r_k  [N];
    t_q16 r_xc [N];
    t_q16 r_s, r_e;
    logic r_fault;
    t_q16 r_xnv [4];

    // memories
    t_q16 m_p [NN];
    logic r_pv [NN];
    t_q16 m_x [N];
    logic r_xv [N];
    t_q16 m_w [2*NN];
    t_q16 r_p_rd, r_x_rd, r_w_rd;
    logic r_p_rdv, r_x_rdv;

    // pipe
    logic                r_s1v, r_s2v, r_s3v;
    t_tag                r_s1_tag, r_s2_tag, r_s3_tag;
    logic [IW-1:0]       r_s1_i, r_s1_j, r_s2_i, r_s2_j, r_s3_i, r_s3_j;
    t_q16                r_s1_a, r_s1_b, r_s1_add, r_s2_add, r_s3_add;
    logic signed [63:0]  r_s2_prod, r_acc, r_aux;

    // divider
    logic [31:0] r_rem, r_dvs;
    logic [47:0] r_quo;
    logic        r_dneg;

    // output
    logic r_ov;
    t_q16 r_est [4];
    logic r_fo;

    function automatic logic [AW-1:0] pidx(logic [IW-1:0] a, logic [IW-1:0] b);
        return AW'(a) * AW'(N) + AW'(b);
    endfunction

    function automatic t_q412 acoef(logic [3:0] row, logic [3:0] col);
        t_q412 v;
        v = '0;
        if (row < 4'(NCOEF)) begin
            v = coef(r_a[row[1:0]], col);
        end
        return v;
    endfunction

    function automatic t_q16 sx16(t_q412 c);
        return {{16{c[15]}}, c};
    endfunction

    // ---------------- issue decode
    logic          s_issue, s_in_ready, s_out_load, s_pipe_empty, s_div_exit;
    logic          s_m_last, s_j_last, s_i_last, s_done_issue, s_use_i, s_use_j;
    logic [CW-1:0] s_nm_last;
    logic [IW-1:0] s_mi;
    logic [AW-1:0] s_p_ra;
    logic [IW-1:0] s_x_ra;
    logic [WAW-1:0] s_w_ra;
    t_q16          s0_a, s0_b, s0_add;
    logic signed [31:0] s_gg;
    t_tag          s0_tag;

    assign s_mi = r_m[IW-1:0];
    assign s_pipe_empty = !r_s1v && !r_s2v && !r_s3v;
    assign s_div_exit = (r_state == ST_DIV) && (r_dcnt == DIV_LAST) && (r_di == IW'(N - 1));

    always_comb begin
        s_nm_last = CW'(N - 1);
        s_use_i   = 1'b1;
        s_use_j   = 1'b0;
        unique case (r_phase)
            PH_PC, PH_CP, PH_XN: begin
            end
            PH_S, PH_E: begin
                s_use_i = 1'b0;
            end
            PH_XC: begin
                s_nm_last = '0;
            end
            PH_PCOR: begin
                s_nm_last = '0;
                s_use_j   = 1'b1;
            end
            PH_T: begin
                s_use_j = 1'b1;
            end
            PH_PN: begin
                s_nm_last = CW'(N);
                s_use_j   = 1'b1;
            end
            default: begin
            end
        endcase
        s_m_last     = (r_m == s_nm_last);
        s_j_last     = !s_use_j || (r_j == IW'(N - 1));
        s_i_last     = !s_use_i || (r_i == IW'(N - 1));
        s_done_issue = s_m_last && s_j_last && s_i_last;
    end

    always_comb begin
        s_gg   = 32'(coef(r_g, 4'(r_i))) * 32'(coef(r_g, 4'(r_j)));
        s0_a   = '0;
        s0_b   = '0;
        s0_add = '0;
        s_p_ra = pidx(r_i, r_j);
        s_x_ra = r_i;
        s_w_ra = WAW'(pidx(s_mi, r_j));
        s0_tag.ph    = r_phase;
        s0_tag.first = (r_m == '0);
        s0_tag.last  = s_m_last;
        s0_tag.aux   = (r_phase == PH_PN) && (r_m == CW'(N));
        case (r_phase)
            PH_PC: begin
                s_p_ra = pidx(r_i, s_mi);
                s0_b   = sx16(coef(r_c, 4'(r_m)));
            end
            PH_CP: begin
                s_p_ra = pidx(s_mi, r_i);
                s0_b   = sx16(coef(r_c, 4'(r_m)));
            end
            PH_S: begin
                s0_a   = r_pc[s_mi];
                s0_b   = sx16(coef(r_c, 4'(r_m)));
                s0_add = {1'b0, r_r};
            end
            PH_E: begin
                s_x_ra = s_mi;
                s0_b   = sx16(coef(r_c, 4'(r_m)));
                s0_add = r_y;
            end
            PH_XC: begin
                s0_a = r_k[r_i];
                s0_b = r_e;
            end
            PH_PCOR: begin
                s0_a = r_k[r_i];
                s0_b = r_cp[r_j];
            end
            PH_XN: begin
                s0_a = r_xc[s_mi];
                s0_b = sx16(acoef(4'(r_i), 4'(r_m)));
            end
            PH_T: begin
                s0_b = sx16(acoef(4'(r_i), 4'(r_m)));
            end
            PH_PN: begin
                s_w_ra = WAW'(NN) + WAW'(pidx(r_i, s_mi));
                s0_a   = s_gg;
                s0_b   = s0_tag.aux ? {1'b0, r_q} : sx16(acoef(4'(r_j), 4'(r_m)));
            end
            default: begin
            end
        endcase
    end

    // ---------------- state machine
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_meas.valid) n_state = ST_RUN;
            ST_RUN:   if (s_done_issue) n_state = ST_DRAIN;
            ST_DRAIN: begin
                if (s_pipe_empty) begin
                    if (r_phase == PH_S) begin
                        n_state = ST_DIV;
                    end else if (r_phase == PH_PN) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_RUN;
                    end
                end
            end
            ST_DIV:   if (s_div_exit) n_state = ST_RUN;
            ST_DONE:  if (!r_ov || o_est.ready) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_in_ready = (r_state == ST_IDLE);
        s_issue    = (r_state == ST_RUN);
        s_out_load = (r_state == ST_DONE) && (!r_ov || o_est.ready);
    end

    assign i_meas.ready = s_in_ready;
    assign i_cfg.ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= PH_PC;
            r_i     <= '0;
            r_j     <= '0;
            r_m     <= '0;
            r_di    <= '0;
            r_dcnt  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_IDLE && i_meas.valid) begin
                r_phase <= PH_PC;
                r_i     <= '0;
                r_j     <= '0;
                r_m     <= '0;
            end
            if (s_issue) begin
                if (s_m_last) begin
                    r_m <= '0;
                    if (s_j_last) begin
                        r_j <= '0;
                        r_i <= s_i_last ? '0 : r_i + 1'b1;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end else begin
                    r_m <= r_m + 1'b1;
                end
            end
            if (r_state == ST_DRAIN && s_pipe_empty) begin
                r_di   <= '0;
                r_dcnt <= '0;
                case (r_phase)
                    PH_PC:   r_phase <= PH_CP;
                    PH_CP:   r_phase <= PH_S;
                    PH_XC:   r_phase <= PH_PCOR;
                    PH_PCOR: r_phase <= PH_XN;
                    PH_XN:   r_phase <= PH_T;
                    PH_T:    r_phase <= PH_PN;
                    PH_E:    r_phase <= PH_XC;
                    default: r_phase <= r_phase;
                endcase
            end
            if (r_state == ST_DIV) begin
                if (r_dcnt == DIV_LAST) begin
                    r_dcnt <= '0;
                    r_di   <= r_di + 1'b1;
                end else begin
                    r_dcnt <= r_dcnt + 1'b1;
                end
                if (s_div_exit) begin
                    r_phase <= PH_E;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_meas.valid) begin
            r_y <= i_meas.measured_position;
        end
    end

    // ---------------- configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_a[k] <= '0;
            end
            r_c <= '0;
            r_g <= '0;
            r_q <= '0;
            r_r <= '0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_TRANS_ROW0:     r_a[0] <= i_cfg.data;
                CFG_TRANS_ROW1:     r_a[1] <= i_cfg.data;
                CFG_TRANS_ROW2:     r_a[2] <= i_cfg.data;
                CFG_TRANS_ROW3:     r_a[3] <= i_cfg.data;
                CFG_OBS_ROW:        r_c    <= i_cfg.data;
                CFG_NOISE_GAIN_COL: r_g    <= i_cfg.data;
                CFG_PROCESS_NOISE:  r_q    <= i_cfg.data[30:0];
                CFG_MEASURE_NOISE:  r_r    <= i_cfg.data[30:0];
                default: begin
                end
            endcase
        end
    end

    // ---------------- stage 1: memory data, multiply
    t_q16 s1_pd, s1_xd, s1_asel, s1_add;
    logic signed [63:0] s1_prod;

    assign s1_pd = r_p_rdv ? r_p_rd : '0;
    assign s1_xd = r_x_rdv ? r_x_rd : '0;

    always_comb begin
        s1_asel = r_s1_a;
        s1_add  = r_s1_add;
        case (r_s1_tag.ph)
            PH_PC, PH_CP: s1_asel = s1_pd;
            PH_E:         s1_asel = s1_xd;
            PH_T:         s1_asel = r_w_rd;
            PH_PN:        s1_asel = r_s1_tag.aux ? r_s1_a : r_w_rd;
            PH_XC:        s1_add  = s1_xd;
            PH_PCOR:      s1_add  = s1_pd;
            default: begin
            end
        endcase
    end

    assign s1_prod = 64'(s1_asel) * 64'(r_s1_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1v <= 1'b0;
            r_s2v <= 1'b0;
            r_s3v <= 1'b0;
        end else begin
            r_s1v <= s_issue;
            r_s2v <= r_s1v;
            r_s3v <= r_s2v && r_s2_tag.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_tag  <= s0_tag;
        r_s1_i    <= r_i;
        r_s1_j    <= r_j;
        r_s1_a    <= s0_a;
        r_s1_b    <= s0_b;
        r_s1_add  <= s0_add;
        r_s2_tag  <= r_s1_tag;
        r_s2_i    <= r_s1_i;
        r_s2_j    <= r_s1_j;
        r_s2_prod <= s1_prod;
        r_s2_add  <= s1_add;
        r_s3_tag  <= r_s2_tag;
        r_s3_i    <= r_s2_i;
        r_s3_j    <= r_s2_j;
        r_s3_add  <= r_s2_add;
        if (r_s2v) begin
            if (r_s2_tag.aux) begin
                r_aux <= r_s2_prod;
            end else if (r_s2_tag.first) begin
                r_acc <= r_s2_prod;
            end else begin
                r_acc <= r_acc + r_s2_prod;
            end
        end
    end

    // ---------------- stage 3: round, add, saturate, write back
    logic signed [63:0] s3_v12, s3_v16, s3_v24, s3_add, s3_pre;
    t_q16 s3_res;

    assign s3_v12 = (r_acc + 64'sd2048) >>> 12;
    assign s3_v16 = (r_acc + 64'sd32768) >>> 16;
    assign s3_v24 = (r_aux + 64'sd8388608) >>> 24;
    assign s3_add = {{32{r_s3_add[31]}}, r_s3_add};

    always_comb begin
        case (r_s3_tag.ph)
            PH_S:    s3_pre = s3_v12 + s3_add;
            PH_E:    s3_pre = s3_add - s3_v12;
            PH_XC:   s3_pre = s3_add + s3_v16;
            PH_PCOR: s3_pre = s3_add - s3_v16;
            PH_PN:   s3_pre = s3_v12 + s3_v24;
            default: s3_pre = s3_v12;
        endcase
        s3_res = sat32(s3_pre);
    end

    logic           s_p_we, s_x_we, s_w_we;
    logic [AW-1:0]  s_p_wa;
    logic [WAW-1:0] s_w_wa;

    assign s_p_we = r_s3v && (r_s3_tag.ph == PH_PN);
    assign s_x_we = r_s3v && (r_s3_tag.ph == PH_XN);
    assign s_w_we = r_s3v && (r_s3_tag.ph == PH_PCOR || r_s3_tag.ph == PH_T);
    assign s_p_wa = pidx(r_s3_i, r_s3_j);
    assign s_w_wa = (r_s3_tag.ph == PH_T) ? WAW'(NN) + WAW'(s_p_wa) : WAW'(s_p_wa);

    always_ff @(posedge i_clk) begin
        if (r_s3v) begin
            case (r_s3_tag.ph)
                PH_PC: r_pc[r_s3_i] <= s3_res;
                PH_CP: r_cp[r_s3_i] <= s3_res;
                PH_S: begin
                    r_s     <= s3_res;
                    r_fault <= (s3_res == '0);
                end
                PH_E:  r_e <= s3_res;
                PH_XC: r_xc[r_s3_i] <= s3_res;
                default: begin
                end
            endcase
        end
        for (int k = 0; k < 4; k++) begin
            if (s_x_we && 4'(r_s3_i) == 4'(k)) begin
                r_xnv[k] <= s3_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_p_we) begin
            m_p[s_p_wa] <= s3_res;
        end
        r_p_rd <= m_p[s_p_ra];
        if (s_x_we) begin
            m_x[r_s3_i] <= s3_res;
        end
        r_x_rd <= m_x[s_x_ra];
        if (s_w_we) begin
            m_w[s_w_wa] <= s3_res;
        end
        r_w_rd <= m_w[s_w_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NN; k++) begin
                r_pv[k] <= 1'b0;
            end
            for (int k = 0; k < N; k++) begin
                r_xv[k] <= 1'b0;
            end
            r_p_rdv <= 1'b0;
            r_x_rdv <= 1'b0;
        end else begin
            if (s_p_we) begin
                r_pv[s_p_wa] <= 1'b1;
            end
            if (s_x_we) begin
                r_xv[r_s3_i] <= 1'b1;
            end
            r_p_rdv <= r_pv[s_p_ra];
            r_x_rdv <= r_xv[s_x_ra];
        end
    end

    // ---------------- gain divider, one quotient bit per cycle
    t_q16        d_pc;
    logic [31:0] d_pcm, d_sm;
    logic [32:0] d_shift;
    logic [33:0] d_diff;
    logic        d_ge;
    t_q16        d_k;

    always_comb begin
        d_pc    = r_pc[r_di];
        d_pcm   = d_pc[31] ? (~d_pc + 32'd1) : d_pc;
        d_sm    = r_s[31] ? (~r_s + 32'd1) : r_s;
        d_shift = {r_rem, r_quo[47]};
        d_diff  = {1'b0, d_shift} - {2'b00, r_dvs};
        d_ge    = !d_diff[33];
        if (r_dneg) begin
            d_k = (r_quo > 48'h0000_8000_0000) ? 32'sh80000000 : (~r_quo[31:0] + 32'd1);
        end else begin
            d_k = (r_quo > 48'h0000_7fff_ffff) ? 32'sh7fffffff : r_quo[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_DIV) begin
            if (r_dcnt == '0) begin
                r_rem  <= '0;
                r_quo  <= {d_pcm, 16'h0000};
                r_dvs  <= d_sm;
                r_dneg <= d_pc[31] ^ r_s[31];
            end else if (r_dcnt == DIV_LAST) begin
                r_k[r_di] <= r_fault ? '0 : d_k;
            end else begin
                r_rem <= d_ge ? d_diff[31:0] : d_shift[31:0];
                r_quo <= {r_quo[46:0], d_ge};
            end
        end
    end

    // ---------------- result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (s_out_load) begin
            r_ov <= 1'b1;
        end else if (o_est.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_out_load) begin
            for (int k = 0; k < 4; k++) begin
                r_est[k] <= (k < N) ? r_xnv[k] : '0;
            end
            r_fo <= r_fault;
        end
    end

    assign o_est.valid          = r_ov;
    assign o_est.est_0          = r_est[0];
    assign o_est.est_1          = r_est[1];
    assign o_est.est_2          = r_est[2];
    assign o_est.est_3          = r_est[3];
    assign o_est.singular_fault = r_fo;

    // ---------------- checks
    a_div_pipe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (!r_s1v && !r_s2v && !r_s3v))
        else $error("divider running with MAC pipe busy");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_ov && !o_est.ready) |=> (r_state == ST_DONE && r_ov))
        else $error("pending result overwritten");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_out_load |=> (r_ov && r_state == ST_IDLE))
        else $error("result not presented after compute");

    a_no_issue_in_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DRAIN) |=> !r_s1v)
        else $error("MAC issue outside run phase");

endmodule
